>>> rtl/sfms_pkg.sv
package sfms_pkg;

	localparam int SERVO_COUNT = 3;

	localparam int DAY_W = 5;
	localparam int SERVO_W = 2;
	localparam int PULSE_W = 13;
	localparam int PHASE_W = 2;
	localparam int ANGLE_W = 8;
	localparam int USEC_W = 12;
	localparam int TICK_W = 16;
	localparam int STEP_W = 3;
	localparam int PROD_W = ANGLE_W + USEC_W;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef logic [SERVO_W-1:0] servo_t;
	typedef logic [ANGLE_W-1:0] angle_t;
	typedef logic [PULSE_W-1:0] pulse_t;
	typedef logic [PHASE_W-1:0] phase_code_t;
	typedef logic [APB_ADDR_W-1:0] apb_addr_t;
	typedef logic [APB_DATA_W-1:0] apb_data_t;

	localparam angle_t MAX_ANGLE = angle_t'(180);
	localparam logic [STEP_W-1:0] FIRST_MOVE = STEP_W'(1);
	localparam logic [STEP_W-1:0] LAST_MOVE = STEP_W'(7);

	// x / 180 == (x >> 2) / 45; 45 by reciprocal, exact for x < 2**20
	localparam int RECIP_W = 19;
	localparam int DIV_SHIFT = 24;
	localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(372828);
	localparam int QUOT_IN_W = PROD_W - 2;
	localparam int MUL_W = QUOT_IN_W + RECIP_W;

	typedef enum logic [2:0] {
		REG_PULSE_MIN   = 3'd0,
		REG_PULSE_SPAN  = 3'd1,
		REG_FIRST_PAUSE = 3'd2,
		REG_ROCK_PAUSE  = 3'd3,
		REG_FINAL_PAUSE = 3'd4,
		REG_ROCK_ANGLE  = 3'd5
	} reg_idx_t;

	localparam logic [USEC_W-1:0] PULSE_MIN_RST = USEC_W'(500);
	localparam logic [USEC_W-1:0] PULSE_SPAN_RST = USEC_W'(2000);
	localparam logic [TICK_W-1:0] FIRST_PAUSE_RST = TICK_W'(1000);
	localparam logic [TICK_W-1:0] ROCK_PAUSE_RST = TICK_W'(100);
	localparam logic [TICK_W-1:0] FINAL_PAUSE_RST = TICK_W'(5000);
	localparam angle_t ROCK_ANGLE_RST = angle_t'(165);

	localparam int DAY_CODES = 2 ** DAY_W;
	typedef servo_t servo_lut_t [DAY_CODES];

	function automatic servo_lut_t build_servo_lut();
		servo_lut_t lut;
		for (int i = 0; i < DAY_CODES; i++) begin
			lut[i] = servo_t'(i % SERVO_COUNT);
		end
		return lut;
	endfunction

	localparam servo_lut_t SERVO_LUT = build_servo_lut();

endpackage

>>> rtl/sfms_if.sv
interface sfms_in_if;
	import sfms_pkg::*;
	logic valid;
	logic ready;
	logic time_match;
	logic [DAY_W-1:0] day_of_month;

	modport source (output valid, output time_match, output day_of_month, input ready);
	modport sink (input valid, input time_match, input day_of_month, output ready);
endinterface

interface sfms_out_if;
	import sfms_pkg::*;
	logic valid;
	logic ready;
	logic write_valid;
	logic [SERVO_W-1:0] servo_sel;
	logic [PULSE_W-1:0] pulse_width_us;
	logic [PHASE_W-1:0] phase;

	modport source (output valid, output write_valid, output servo_sel,
		output pulse_width_us, output phase, input ready);
	modport sink (input valid, input write_valid, input servo_sel,
		input pulse_width_us, input phase, output ready);
endinterface

>>> rtl/servo_feed_motion_sequencer_core.sv
// channel  dir  payload                                          handshake
// in_ch    in   time_match, day_of_month                         valid/ready
// out_ch   out  write_valid, servo_sel, pulse_width_us, phase    valid/ready
// apb      in   6 regs at 4*i, 32-bit data                       psel/penable, pready=1
//
// One request per cycle sustained while out_ch.ready stays high. Sequencer state updates in the accept cycle;
// the pulse width then takes a multiply stage (angle*span) and a reciprocal
// divide-by-180 stage, and the result is offered from the stage-3 output register.
// arst_n clears sequencer state, pipeline valids and registers to defaults.
// Each stage holds when the next is full and stalled; in_ch.ready drops only
// when all three stages are full and out_ch.ready is low.
module servo_feed_motion_sequencer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	sfms_in_if.sink              in_ch,
	sfms_out_if.source           out_ch,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  sfms_pkg::apb_addr_t  paddr,
	input  sfms_pkg::apb_data_t  pwdata,
	output sfms_pkg::apb_data_t  prdata,
	output logic                 pready
);
	import sfms_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_START = 2'd1,
		PH_PAUSE = 2'd2
	} phase_t;

	// config registers
	logic [USEC_W-1:0] pulse_min_q, pulse_span_q;
	logic [TICK_W-1:0] first_pause_q, rock_pause_q, final_pause_q;
	angle_t            rock_angle_q;
	logic [2:0]        reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q   <= PULSE_MIN_RST;
			pulse_span_q  <= PULSE_SPAN_RST;
			first_pause_q <= FIRST_PAUSE_RST;
			rock_pause_q  <= ROCK_PAUSE_RST;
			final_pause_q <= FINAL_PAUSE_RST;
			rock_angle_q  <= ROCK_ANGLE_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_PULSE_MIN:   pulse_min_q   <= pwdata[USEC_W-1:0];
				REG_PULSE_SPAN:  pulse_span_q  <= pwdata[USEC_W-1:0];
				REG_FIRST_PAUSE: first_pause_q <= pwdata[TICK_W-1:0];
				REG_ROCK_PAUSE:  rock_pause_q  <= pwdata[TICK_W-1:0];
				REG_FINAL_PAUSE: final_pause_q <= pwdata[TICK_W-1:0];
				REG_ROCK_ANGLE:  rock_angle_q  <= pwdata[ANGLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PULSE_MIN:   prdata = APB_DATA_W'(pulse_min_q);
			REG_PULSE_SPAN:  prdata = APB_DATA_W'(pulse_span_q);
			REG_FIRST_PAUSE: prdata = APB_DATA_W'(first_pause_q);
			REG_ROCK_PAUSE:  prdata = APB_DATA_W'(rock_pause_q);
			REG_FINAL_PAUSE: prdata = APB_DATA_W'(final_pause_q);
			REG_ROCK_ANGLE:  prdata = APB_DATA_W'(rock_angle_q);
			default:         prdata = '0;
		endcase
	end

	// pipeline control
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3, accept;

	assign en3 = !v_s3 || out_ch.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ch.ready = en1;
	assign accept = in_ch.valid && en1;

	// sequencer
	phase_t            phase_q, phase_nxt;
	logic [STEP_W-1:0] step_q, step_nxt;
	logic [TICK_W-1:0] elapsed_q, elapsed_nxt, elapsed_inc;
	servo_t            servo_q, servo_nxt;
	logic [TICK_W-1:0] pause;
	angle_t            rock_clamped, move_angle, wr_angle;
	logic              wr;
	phase_code_t       ph_out;

	assign rock_clamped = (rock_angle_q > MAX_ANGLE) ? MAX_ANGLE : rock_angle_q;
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);

	always_comb begin
		if (step_q == FIRST_MOVE)
			pause = first_pause_q;
		else if (step_q == LAST_MOVE)
			pause = final_pause_q;
		else
			pause = rock_pause_q;
		if (step_q == LAST_MOVE)
			move_angle = '0;
		else
			move_angle = step_q[0] ? rock_clamped : MAX_ANGLE;
	end

	always_comb begin
		phase_nxt   = phase_q;
		step_nxt    = step_q;
		elapsed_nxt = elapsed_q;
		servo_nxt   = servo_q;
		wr          = 1'b0;
		wr_angle    = '0;
		ph_out      = phase_code_t'(phase_q);
		case (phase_q)
			PH_START: begin
				wr          = 1'b1;
				wr_angle    = MAX_ANGLE;
				phase_nxt   = PH_PAUSE;
				step_nxt    = FIRST_MOVE;
				elapsed_nxt = '0;
			end
			PH_PAUSE: begin
				if (step_q == '0) begin
					phase_nxt   = PH_IDLE;
					elapsed_nxt = '0;
				end else begin
					elapsed_nxt = elapsed_inc;
					if (elapsed_inc >= pause) begin
						wr          = 1'b1;
						wr_angle    = move_angle;
						elapsed_nxt = '0;
						if (step_q == LAST_MOVE) begin
							phase_nxt = PH_IDLE;
							step_nxt  = '0;
						end else begin
							step_nxt = step_q + STEP_W'(1);
						end
					end
				end
			end
			default: begin
				ph_out    = phase_code_t'(PH_IDLE);
				phase_nxt = PH_IDLE;
				if (in_ch.time_match) begin
					servo_nxt   = SERVO_LUT[in_ch.day_of_month];
					wr          = 1'b1;
					wr_angle    = '0;
					phase_nxt   = PH_START;
					step_nxt    = '0;
					elapsed_nxt = '0;
				end
			end
		endcase
	end

	// stage 1: sequencer state and write decision
	logic        wr_s1;
	servo_t      servo_s1;
	angle_t      angle_s1;
	phase_code_t phase_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			step_q    <= '0;
			elapsed_q <= '0;
			servo_q   <= '0;
			v_s1      <= 1'b0;
		end else begin
			if (accept) begin
				phase_q   <= phase_nxt;
				step_q    <= step_nxt;
				elapsed_q <= elapsed_nxt;
				servo_q   <= servo_nxt;
			end
			if (en1)
				v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_s1    <= wr;
			servo_s1 <= servo_nxt;
			angle_s1 <= wr_angle;
			phase_s1 <= ph_out;
		end
	end

	// stage 2: angle * span
	logic        wr_s2;
	servo_t      servo_s2;
	logic [PROD_W-1:0] prod_s2;
	phase_code_t phase_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en2)
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			wr_s2    <= wr_s1;
			servo_s2 <= servo_s1;
			prod_s2  <= PROD_W'(angle_s1) * PROD_W'(pulse_span_q);
			phase_s2 <= phase_s1;
		end
	end

	// stage 3: divide by 180, add min
	logic [MUL_W-1:0]  quot_mul;
	logic [USEC_W-1:0] quot;
	pulse_t            pulse;

	assign quot_mul = MUL_W'(prod_s2[PROD_W-1:2]) * MUL_W'(DIV_RECIP);
	assign quot = quot_mul[DIV_SHIFT +: USEC_W];
	assign pulse = PULSE_W'(pulse_min_q) + PULSE_W'(quot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s3 <= 1'b0;
		else if (en3)
			v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			out_ch.write_valid    <= wr_s2;
			out_ch.servo_sel      <= wr_s2 ? servo_s2 : '0;
			out_ch.pulse_width_us <= wr_s2 ? pulse : '0;
			out_ch.phase          <= phase_s2;
		end
	end

	assign out_ch.valid = v_s3;

endmodule

>>> sim/servo_feed_motion_sequencer_core_tb.sv
`timescale 1ns / 100ps

module servo_feed_motion_sequencer_core_tb;
	import sfms_pkg::*;

	typedef enum logic [PHASE_W-1:0] {
		SEQ_IDLE  = 2'd0,
		SEQ_START = 2'd1,
		SEQ_PAUSE = 2'd2
	} seq_phase_t;

	typedef struct packed {
		logic             time_match;
		logic [DAY_W-1:0] day;
	} feed_req_t;

	typedef struct packed {
		logic        write_valid;
		servo_t      servo_sel;
		pulse_t      pulse_width_us;
		phase_code_t phase;
	} servo_wr_t;

	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;
	localparam int LIMIT = 500000;
	localparam int GAP_MAX = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT = 620;
	localparam int HOLD_CYCLES = 150;
	localparam int RAND_PHASES = 8;
	localparam int RAND_PER_PHASE = 241;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	apb_addr_t paddr;
	apb_data_t pwdata;
	apb_data_t prdata;
	logic pready;

	sfms_in_if in_ch ();
	sfms_out_if out_ch ();

	servo_feed_motion_sequencer_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// register mirror
	logic [USEC_W-1:0] pulse_min = PULSE_MIN_RST;
	logic [USEC_W-1:0] pulse_span = PULSE_SPAN_RST;
	logic [TICK_W-1:0] first_pause = FIRST_PAUSE_RST;
	logic [TICK_W-1:0] rock_pause = ROCK_PAUSE_RST;
	logic [TICK_W-1:0] final_pause = FINAL_PAUSE_RST;
	angle_t rock_angle = ROCK_ANGLE_RST;

	// sequencer mirror
	seq_phase_t seq_ph = SEQ_IDLE;
	logic [STEP_W-1:0] move_step = '0;
	logic [TICK_W-1:0] elapsed = '0;
	servo_t active_servo = '0;

	feed_req_t ticks_to_send[$];
	servo_wr_t predicted_writes[$];
	feed_req_t cur_req;

	int send_wait = 0;
	int recv_wait = 0;
	bit send_idle = 1'b0;
	bit recv_idle = 1'b0;
	logic rx_hold;

	int errors = 0;
	int ticks_sent = 0;
	int writes_checked = 0;
	int feed_runs = 0;
	int servo_updates = 0;
	int settings_applied = 0;
	int cycle_count = 0;

	function automatic pulse_t pulse_for(angle_t angle);
		int unsigned deg;
		deg = 32'((angle > MAX_ANGLE) ? MAX_ANGLE : angle);
		return pulse_t'(pulse_min + deg * pulse_span / MAX_ANGLE);
	endfunction

	function automatic logic [TICK_W-1:0] pause_for(logic [STEP_W-1:0] step);
		if (step == FIRST_MOVE)
			return first_pause;
		if (step == LAST_MOVE)
			return final_pause;
		return rock_pause;
	endfunction

	function automatic angle_t angle_for(logic [STEP_W-1:0] step);
		if (step == LAST_MOVE)
			return angle_t'(0);
		return step[0] ? rock_angle : MAX_ANGLE;
	endfunction

	function automatic servo_wr_t sequence_tick(feed_req_t req);
		servo_wr_t res;
		res = '0;
		res.phase = seq_ph;
		if (seq_ph == SEQ_START) begin
			res.write_valid = 1'b1;
			res.pulse_width_us = pulse_for(MAX_ANGLE);
			seq_ph = SEQ_PAUSE;
			move_step = FIRST_MOVE;
			elapsed = '0;
		end else if (seq_ph == SEQ_PAUSE) begin
			if (move_step < FIRST_MOVE || move_step > LAST_MOVE) begin
				seq_ph = SEQ_IDLE;
				move_step = '0;
				elapsed = '0;
			end else begin
				if (elapsed != '1)
					elapsed++;
				if (elapsed >= pause_for(move_step)) begin
					res.write_valid = 1'b1;
					res.pulse_width_us = pulse_for(angle_for(move_step));
					elapsed = '0;
					if (move_step == LAST_MOVE) begin
						seq_ph = SEQ_IDLE;
						move_step = '0;
					end else begin
						move_step++;
					end
				end
			end
		end else begin
			res.phase = SEQ_IDLE;
			seq_ph = SEQ_IDLE;
			if (req.time_match) begin
				active_servo = servo_t'(req.day % SERVO_COUNT);
				res.write_valid = 1'b1;
				res.pulse_width_us = pulse_for(angle_t'(0));
				seq_ph = SEQ_START;
				move_step = '0;
				elapsed = '0;
				feed_runs++;
			end
		end
		if (res.write_valid) begin
			res.servo_sel = active_servo;
			servo_updates++;
		end
		return res;
	endfunction

	function automatic int draw_gap(bit on);
		return on ? int'($urandom_range(0, GAP_MAX)) : 0;
	endfunction

	function automatic apb_data_t noisy(int unsigned val, int w);
		apb_data_t v;
		v = $urandom();
		return ((v >> w) << w) | apb_data_t'(val);
	endfunction

	function automatic apb_data_t mirror_of(logic [2:0] idx);
		case (idx)
			REG_PULSE_MIN:   return apb_data_t'(pulse_min);
			REG_PULSE_SPAN:  return apb_data_t'(pulse_span);
			REG_FIRST_PAUSE: return apb_data_t'(first_pause);
			REG_ROCK_PAUSE:  return apb_data_t'(rock_pause);
			REG_FINAL_PAUSE: return apb_data_t'(final_pause);
			REG_ROCK_ANGLE:  return apb_data_t'(rock_angle);
			default:         return '0;
		endcase
	endfunction

	function automatic int unsigned pick_usec();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 4095;
			default: return $urandom_range(0, 4095);
		endcase
	endfunction

	function automatic int unsigned pick_pause();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return $urandom_range(10, 30);
			default: return $urandom_range(1, 5);
		endcase
	endfunction

	function automatic int unsigned pick_angle();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 180;
			2: return $urandom_range(181, 255);
			default: return $urandom_range(0, 180);
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, writes_checked);
		errors++;
	endtask

	task automatic queue_req(bit match, int day);
		feed_req_t r;
		r.time_match = match;
		r.day = DAY_W'(day);
		ticks_to_send.push_back(r);
	endtask

	task automatic drain();
		while (ticks_to_send.size() != 0 || in_ch.valid || predicted_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, apb_data_t value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= apb_addr_t'({idx, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PULSE_MIN:   pulse_min = value[USEC_W-1:0];
			REG_PULSE_SPAN:  pulse_span = value[USEC_W-1:0];
			REG_FIRST_PAUSE: first_pause = value[TICK_W-1:0];
			REG_ROCK_PAUSE:  rock_pause = value[TICK_W-1:0];
			REG_FINAL_PAUSE: final_pause = value[TICK_W-1:0];
			REG_ROCK_ANGLE:  rock_angle = value[ANGLE_W-1:0];
			default: ;
		endcase
		settings_applied++;
	endtask

	task automatic check_regs();
		apb_data_t got;
		for (int i = 0; i <= int'(REG_ROCK_ANGLE); i++) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b0;
			paddr <= apb_addr_t'(i * 4);
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			got = prdata;
			psel <= 1'b0;
			penable <= 1'b0;
			if (got !== mirror_of(3'(i)))
				report_mismatch($sformatf("register %0d readback", i), got, mirror_of(3'(i)));
		end
	endtask

	task automatic check_result();
		servo_wr_t want;
		if (predicted_writes.size() == 0) begin
			report_mismatch("result with nothing expected", 32'(out_ch.pulse_width_us), 0);
			return;
		end
		want = predicted_writes.pop_front();
		writes_checked++;
		if (out_ch.write_valid !== want.write_valid)
			report_mismatch("write_valid", 32'(out_ch.write_valid), 32'(want.write_valid));
		if (out_ch.servo_sel !== want.servo_sel)
			report_mismatch("servo_sel", 32'(out_ch.servo_sel), 32'(want.servo_sel));
		if (out_ch.pulse_width_us !== want.pulse_width_us)
			report_mismatch("pulse_width_us", 32'(out_ch.pulse_width_us),
				32'(want.pulse_width_us));
		if (out_ch.phase !== want.phase)
			report_mismatch("phase", 32'(out_ch.phase), 32'(want.phase));
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// tick driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			send_wait = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predicted_writes.push_back(sequence_tick(cur_req));
				ticks_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_wait > 0) begin
					send_wait--;
					in_ch.valid <= 1'b0;
				end else if (ticks_to_send.size() > 0) begin
					cur_req = ticks_to_send.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.time_match <= cur_req.time_match;
					in_ch.day_of_month <= cur_req.day;
					send_wait = draw_gap(send_idle);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				check_result();
				recv_wait = draw_gap(recv_idle);
			end
			if (rx_hold) begin
				out_ch.ready <= 1'b0;
			end else if (recv_wait > 0) begin
				recv_wait--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// long output stall to back up the pipeline
	initial begin
		rx_hold = 1'b0;
		wait (ticks_sent >= HOLD_AT);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			predicted_writes.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.time_match = 1'b0;
		in_ch.day_of_month = '0;
		out_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: start on day 0, ignored match while running
		check_regs();
		queue_req(1, 0);
		queue_req(1, 31);
		queue_req(1, 5);
		queue_req(0, 0);
		drain();

		// extremes: max pulse, clamped angle, zero rock pause
		write_reg(REG_FIRST_PAUSE, noisy(65535, TICK_W));
		write_reg(REG_ROCK_PAUSE, noisy(0, TICK_W));
		write_reg(REG_FINAL_PAUSE, noisy(1, TICK_W));
		write_reg(REG_PULSE_MIN, noisy(4095, USEC_W));
		write_reg(REG_PULSE_SPAN, noisy(4095, USEC_W));
		write_reg(REG_ROCK_ANGLE, noisy(255, ANGLE_W));
		check_regs();
		queue_req(0, 21);
		queue_req(1, 10);
		drain();

		// first pause lowered while a run is still in progress
		write_reg(REG_FIRST_PAUSE, noisy(3, TICK_W));
		for (int i = 0; i < 7; i++)
			queue_req(bit'(i % 2), i * 4 + 3);
		queue_req(0, 31);
		queue_req(1, 31);
		queue_req(1, 29);
		queue_req(0, 0);
		queue_req(1, 2);
		queue_req(0, 16);
		queue_req(1, 8);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			send_idle = (p == 1 || p == 2) ? 1'b1 : (p == 0) ? 1'b0 : bit'($urandom_range(0, 1));
			recv_idle = (p == 1 || p == 3) ? 1'b1 : (p == 0) ? 1'b0 : bit'($urandom_range(0, 1));
			write_reg(REG_PULSE_MIN, noisy((p == 0) ? 0 : pick_usec(), USEC_W));
			write_reg(REG_PULSE_SPAN, noisy((p == 0) ? 0 : pick_usec(), USEC_W));
			write_reg(REG_FIRST_PAUSE, noisy(pick_pause(), TICK_W));
			write_reg(REG_ROCK_PAUSE, noisy(pick_pause(), TICK_W));
			write_reg(REG_FINAL_PAUSE, noisy(pick_pause(), TICK_W));
			write_reg(REG_ROCK_ANGLE, noisy(pick_angle(), ANGLE_W));
			write_reg(p[0] ? REG_SPARE_A : REG_SPARE_B, $urandom());
			check_regs();
			repeat (RAND_PER_PHASE)
				queue_req($urandom_range(0, 3) == 0, $urandom_range(0, 31));
			drain();
		end

		$display("ran %0d ticks, checked %0d results across %0d register writes",
			ticks_sent, writes_checked, settings_applied);
		$display("%0d feeding runs started, %0d servo writes predicted",
			feed_runs, servo_updates);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
